@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UVS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the following cycle.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/uvs_pkg.sv @@
// Shared constants and types of the unique value set unit.
package uvs_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STAT_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT    = 3'd0,
    K_SEARCH    = 3'd1,
    K_LIST_NEW  = 3'd2,
    K_LIST_ASC  = 3'd3,
    K_LIST_DESC = 3'd4,
    K_CLEAR     = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ELEMENT  = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_CLEARED  = 3'd7
  } status_e;

endpackage

@@ rtl/uvs_if.sv @@
// Request and result channel interfaces of the unique value set unit.
interface uvs_in_if import uvs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface uvs_out_if import uvs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] element;
  logic                     last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink (input valid, input status, input element, input last, output ready);
endinterface

@@ rtl/uvs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module uvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/unique_value_set_with_sorted_readout_unit.sv @@
// Top level of the unique value set unit with sorted readout.
//
//   channel  dir  modport  payload
//   in_i     in   sink     kind[2:0], value[31:0] signed
//   out_o    out  source   status[2:0], element[31:0] signed, last
//
// Insert and search scan the entry memory one word a cycle, then give one result.
// Newest-first listing reads an entry and emits it before the next read on the single read port.
// Sorted listing runs one selection pass over the memory per entry.
// A new request is taken only in idle; a held output register stalls the sequencer.
// Reset clears the entry count, state and output valid; the memory content is never cleared.
module unique_value_set_with_sorted_readout_unit import uvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  uvs_in_if.sink    in_i,
  uvs_out_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LREAD = 6'b000100,
    S_LEMIT = 6'b001000,
    S_SEMIT = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic signed [DATA_W-1:0] out_element_q;
  logic                     out_last_q;

  logic [KIND_W-1:0]        kind_q, kind_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  status_e                  resp_q, resp_d;
  logic [CNT_W-1:0]         scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0]         emit_cnt_q, emit_cnt_d;
  logic [IDX_W-1:0]         lidx_q, lidx_d;
  logic                     hit_q, hit_d;
  logic                     asc_q, asc_d;
  logic                     sort_q, sort_d;
  logic                     best_vld_q, best_vld_d;
  logic signed [DATA_W-1:0] best_q, best_d;
  logic                     bound_vld_q, bound_vld_d;
  logic signed [DATA_W-1:0] bound_q, bound_d;
  logic                     rd_vld_q;

  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_data;

  logic                     push, push_last, out_space, hit_now, cand_ok, emit_last;
  status_e                  push_status;
  logic signed [DATA_W-1:0] push_element;

  uvs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_data   = $signed(ram_rdata);
  assign in_i.ready = (state_q == S_IDLE);
  assign out_space = !out_valid_q || out_o.ready;
  assign hit_now   = hit_q || (rd_vld_q && (rd_data == value_q));
  assign emit_last = (CNT_W'(emit_cnt_q + 1'b1) == count_q);

  always_comb begin
    if (asc_q) begin
      cand_ok = (!bound_vld_q || (rd_data > bound_q)) && (!best_vld_q || (rd_data < best_q));
    end else begin
      cand_ok = (!bound_vld_q || (rd_data < bound_q)) && (!best_vld_q || (rd_data > best_q));
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    kind_d       = kind_q;
    value_d      = value_q;
    resp_d       = resp_q;
    scan_cnt_d   = scan_cnt_q;
    emit_cnt_d   = emit_cnt_q;
    lidx_d       = lidx_q;
    hit_d        = hit_q;
    asc_d        = asc_q;
    sort_d       = sort_q;
    best_vld_d   = best_vld_q;
    best_d       = best_q;
    bound_vld_d  = bound_vld_q;
    bound_d      = bound_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_re       = 1'b0;
    ram_raddr    = scan_cnt_q[IDX_W-1:0];
    push         = 1'b0;
    push_status  = resp_q;
    push_element = value_q;
    push_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d      = in_i.kind;
          value_d     = in_i.value;
          scan_cnt_d  = '0;
          emit_cnt_d  = '0;
          hit_d       = 1'b0;
          best_vld_d  = 1'b0;
          bound_vld_d = 1'b0;
          lidx_d      = IDX_W'(count_q - 1'b1);
          asc_d       = (in_i.kind == K_LIST_ASC);
          case (in_i.kind)
            K_INSERT, K_SEARCH: begin
              sort_d  = 1'b0;
              state_d = S_SCAN;
            end
            K_LIST_NEW: begin
              resp_d  = ST_EMPTY;
              state_d = (count_q == '0) ? S_RESP : S_LREAD;
            end
            K_LIST_ASC, K_LIST_DESC: begin
              sort_d  = 1'b1;
              resp_d  = ST_EMPTY;
              state_d = (count_q == '0) ? S_RESP : S_SCAN;
            end
            K_CLEAR: begin
              count_d = '0;
              resp_d  = ST_CLEARED;
              state_d = S_RESP;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_re = (scan_cnt_q < count_q);
        if (ram_re) begin
          scan_cnt_d = CNT_W'(scan_cnt_q + 1'b1);
        end
        hit_d = hit_now;
        if (rd_vld_q && cand_ok) begin
          best_d     = rd_data;
          best_vld_d = 1'b1;
        end
        if (scan_cnt_q == count_q) begin
          state_d = S_RESP;
          if (sort_q) begin
            state_d = S_SEMIT;
          end else if (kind_q == K_SEARCH) begin
            resp_d = hit_now ? ST_FOUND : ST_NOTFOUND;
          end else if (hit_now) begin
            resp_d = ST_DUP;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            resp_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = CNT_W'(count_q + 1'b1);
            resp_d  = ST_INSERTED;
          end
        end
      end
      S_SEMIT: begin
        push_status  = ST_ELEMENT;
        push_element = best_q;
        push_last    = emit_last;
        if (out_space) begin
          push        = 1'b1;
          emit_cnt_d  = CNT_W'(emit_cnt_q + 1'b1);
          bound_d     = best_q;
          bound_vld_d = 1'b1;
          best_vld_d  = 1'b0;
          scan_cnt_d  = '0;
          state_d     = emit_last ? S_IDLE : S_SCAN;
        end
      end
      S_LREAD: begin
        ram_re    = 1'b1;
        ram_raddr = lidx_q;
        state_d   = S_LEMIT;
      end
      S_LEMIT: begin
        push_status  = ST_ELEMENT;
        push_element = rd_data;
        push_last    = (lidx_q == '0);
        if (out_space) begin
          push    = 1'b1;
          lidx_d  = IDX_W'(lidx_q - 1'b1);
          state_d = (lidx_q == '0) ? S_IDLE : S_LREAD;
        end
      end
      S_RESP: begin
        if (out_space) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= ram_re && (state_q == S_SCAN);
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    value_q     <= value_d;
    resp_q      <= resp_d;
    scan_cnt_q  <= scan_cnt_d;
    emit_cnt_q  <= emit_cnt_d;
    lidx_q      <= lidx_d;
    hit_q       <= hit_d;
    asc_q       <= asc_d;
    sort_q      <= sort_d;
    best_vld_q  <= best_vld_d;
    best_q      <= best_d;
    bound_vld_q <= bound_vld_d;
    bound_q     <= bound_d;
    if (push) begin
      out_status_q  <= push_status;
      out_element_q <= push_element;
      out_last_q    <= push_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.element = out_element_q;
  assign out_o.last    = out_last_q;

endmodule

@@ rtl/uvs_checker.sv @@
// Port-level checker for the unique value set unit and its bind.
`include "assert_macros.svh"

module uvs_checker import uvs_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic [KIND_W-1:0]        in_kind_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [STAT_W-1:0]        out_status_i,
  input logic signed [DATA_W-1:0] out_element_i,
  input logic                     out_last_i
);

  logic in_beat, known_kind, out_stall;

  assign in_beat    = in_valid_i && in_ready_i;
  assign known_kind = (in_kind_i <= KIND_W'(K_CLEAR));
  assign out_stall  = out_valid_i && !out_ready_i;

  `UVS_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_beat && known_kind, !in_ready_i)
  `UVS_ASSERT_NEXT(a_idle_after_unknown, clk_i, rst_ni, in_beat && !known_kind, in_ready_i)
  `UVS_ASSERT(a_single_is_last, clk_i, rst_ni,
              !out_valid_i || (out_status_i == STAT_W'(ST_ELEMENT)) || out_last_i)
  `UVS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `UVS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall,
                   $stable(out_status_i) && $stable(out_element_i) && $stable(out_last_i))

endmodule

bind unique_value_set_with_sorted_readout_unit uvs_checker u_uvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_element_i (out_o.element),
  .out_last_i    (out_o.last)
);
